>>> src/wps_pkg.sv
// Package: shared types and constants of the waveform peak segmenter.
`default_nettype none
package wps_pkg;

  localparam int THRESH_W    = 16;
  localparam int PEDESTAL_W  = 12;
  localparam int INDEX_W     = 8;
  localparam int AMPLITUDE_W = 13;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [THRESH_W-1:0]   THRESH_RESET   = 16'd32;
  localparam logic [PEDESTAL_W-1:0] PEDESTAL_RESET = 12'd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NOISE_THRESHOLD = 1'b0,
    REG_PEDESTAL        = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [INDEX_W-1:0]            peak_index;
    logic signed [AMPLITUDE_W-1:0] peak_amplitude;
    logic                          last_of_waveform;
  } peak_t;

  // Up to two result items produced by one accepted sample, in order.
  typedef struct packed {
    logic [1:0] count;
    peak_t      first;
    peak_t      second;
  } push_t;

endpackage
`default_nettype wire

>>> src/sample_if.sv
// Interface: input sample channel with valid/ready handshake.
`default_nettype none
interface sample_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_value;
  logic                   last_sample;

  modport source (output valid, output sample_value, output last_sample, input ready);
  modport sink   (input valid, input sample_value, input last_sample, output ready);
endinterface
`default_nettype wire

>>> src/peak_if.sv
// Interface: output peak channel with valid/ready handshake.
`default_nettype none
interface peak_if
  import wps_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic [INDEX_W-1:0]            peak_index;
  logic signed [AMPLITUDE_W-1:0] peak_amplitude;
  logic                          last_of_waveform;

  modport source (output valid, output peak_index, output peak_amplitude,
                  output last_of_waveform, input ready);
  modport sink   (input valid, input peak_index, input peak_amplitude,
                  input last_of_waveform, output ready);
endinterface
`default_nettype wire

>>> src/wps_step.sv
// Segment tracker: per-sample hysteresis logic and segment state registers.
`default_nettype none
module wps_step
  import wps_pkg::*;
#(
  parameter int SAMPLE_BITS      = 12,
  parameter int MAX_SAMPLES      = 256,
  parameter int THRESH_FRAC_BITS = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   accept,
  input  wire logic [SAMPLE_BITS-1:0] sample_value,
  input  wire logic                   last_sample,
  input  wire logic [THRESH_W-1:0]    noise_threshold,
  input  wire logic [PEDESTAL_W-1:0]  pedestal,
  output push_t                       push
);

  localparam int CNT_W  = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
  localparam int SCL_W  = SAMPLE_BITS + THRESH_FRAC_BITS;
  localparam int CMP_W  = (SCL_W > THRESH_W) ? SCL_W : THRESH_W;
  localparam int AMP_W  = ((SAMPLE_BITS > PEDESTAL_W) ? SAMPLE_BITS : PEDESTAL_W) + 1;
  localparam logic [CNT_W-1:0] IDX_LIMIT = CNT_W'(MAX_SAMPLES - 1);

  logic [CNT_W-1:0]       sample_counter, sample_counter_next;
  logic [SAMPLE_BITS-1:0] previous_sample, previous_sample_next;
  logic [SAMPLE_BITS-1:0] segment_maximum, segment_maximum_next;
  logic [CNT_W-1:0]       segment_max_position, segment_max_position_next;
  logic                   falling_seen, falling_seen_next;
  logic                   segment_open, segment_open_next;

  logic signed [SAMPLE_BITS:0] fall, rise;
  logic                        fall_big, rise_big, fall_any, close;

  // True when a signed difference times 2^frac exceeds the threshold.
  function automatic logic beyond(input logic signed [SAMPLE_BITS:0] diff,
                                  input logic [THRESH_W-1:0] thr);
    logic [CMP_W-1:0] scaled;
    scaled = CMP_W'(diff[SAMPLE_BITS-1:0]) << THRESH_FRAC_BITS;
    return !diff[SAMPLE_BITS] && (scaled > CMP_W'(thr));
  endfunction

  function automatic peak_t make_peak(input logic [SAMPLE_BITS-1:0] maximum,
                                      input logic [CNT_W-1:0] position,
                                      input logic [PEDESTAL_W-1:0] ped,
                                      input logic last);
    logic [AMP_W-1:0]       amp;
    logic [CNT_W+INDEX_W-1:0] pos_ext;
    peak_t                  p;
    amp     = AMP_W'(maximum) - AMP_W'(ped);
    pos_ext = {{INDEX_W{1'b0}}, position};
    p.peak_index       = pos_ext[INDEX_W-1:0];
    p.peak_amplitude   = amp[AMPLITUDE_W-1:0];
    p.last_of_waveform = last;
    return p;
  endfunction

  always_comb begin
    fall     = $signed({1'b0, previous_sample}) - $signed({1'b0, sample_value});
    rise     = -fall;
    fall_big = beyond(fall, noise_threshold);
    rise_big = beyond(rise, noise_threshold);
    fall_any = falling_seen || fall_big;
    close    = segment_open && fall_any && rise_big;

    sample_counter_next       = sample_counter;
    previous_sample_next      = previous_sample;
    segment_maximum_next      = segment_maximum;
    segment_max_position_next = segment_max_position;
    falling_seen_next         = falling_seen;
    segment_open_next         = segment_open;

    if (!segment_open || close) begin
      segment_maximum_next      = sample_value;
      segment_max_position_next = sample_counter;
      previous_sample_next      = sample_value;
      falling_seen_next         = 1'b0;
      segment_open_next         = 1'b1;
    end else begin
      if (sample_value > segment_maximum) begin
        segment_maximum_next      = sample_value;
        segment_max_position_next = sample_counter;
      end
      previous_sample_next = sample_value;
      falling_seen_next    = fall_any;
    end

    if (last_sample) begin
      segment_open_next   = 1'b0;
      falling_seen_next   = 1'b0;
      sample_counter_next = '0;
    end else if (sample_counter < IDX_LIMIT) begin
      sample_counter_next = sample_counter + 1'b1;
    end

    // Closed segment goes first, the waveform's final peak after it.
    push.second = make_peak(segment_maximum_next, segment_max_position_next,
                            pedestal, 1'b1);
    if (close) begin
      push.first = make_peak(segment_maximum, segment_max_position, pedestal, 1'b0);
    end else begin
      push.first = push.second;
    end
    push.count = accept ? (2'(close) + 2'(last_sample)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter       <= '0;
      previous_sample      <= '0;
      segment_maximum      <= '0;
      segment_max_position <= '0;
      falling_seen         <= 1'b0;
      segment_open         <= 1'b0;
    end else if (accept) begin
      sample_counter       <= sample_counter_next;
      previous_sample      <= previous_sample_next;
      segment_maximum      <= segment_maximum_next;
      segment_max_position <= segment_max_position_next;
      falling_seen         <= falling_seen_next;
      segment_open         <= segment_open_next;
    end
  end

endmodule
`default_nettype wire

>>> src/wps_queue.sv
// Result queue: two-wide push, one-wide pop, registered entries.
`default_nettype none
module wps_queue
  import wps_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  push_t      push,
  input  wire logic  pop_ready,
  output logic       pop_valid,
  output peak_t      head,
  output logic       room_for_two
);

  peak_t                  entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_CNT_W-1:0] fill, fill_next;
  logic                   pop;

  assign pop_valid    = (fill != '0);
  assign head         = entries[rd_ptr];
  assign pop          = pop_valid && pop_ready;
  assign room_for_two = (fill <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
  assign fill_next    = fill + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + 1'b1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill_next;
    end
  end

endmodule
`default_nettype wire

>>> src/waveform_peak_segmenter_core.sv
// Top level: waveform peak segmenter with config registers and result queue.
// A result item is written into the queue registers at the edge that accepts the sample that closes it.
// Throughput: one sample per cycle; the queue drains one result per cycle while the sink
// is ready, and a sample is refused only while fewer than two queue slots are free.
// Reset (rst, synchronous): no segment open, index 0, queue empty,
// noise_threshold = 32, pedestal = 0.
`default_nettype none
module waveform_peak_segmenter_core
  import wps_pkg::*;
#(
  parameter int SAMPLE_BITS      = 12,
  parameter int MAX_SAMPLES      = 256,
  parameter int THRESH_FRAC_BITS = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  sample_if.sink                      sample_in,
  peak_if.source                      peak_out
);

  logic [THRESH_W-1:0]   noise_threshold;
  logic [PEDESTAL_W-1:0] pedestal;
  logic                  accept;
  logic                  room_for_two;
  push_t                 push;
  peak_t                 head;

  // Configuration registers; write them only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_threshold <= THRESH_RESET;
      pedestal        <= PEDESTAL_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_NOISE_THRESHOLD: noise_threshold <= cfg_data;
        REG_PEDESTAL:        pedestal        <= cfg_data[PEDESTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold off new samples until the queue can absorb the worst case of two items.
  assign sample_in.ready = room_for_two;
  assign accept          = sample_in.valid && room_for_two;

  wps_step #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .MAX_SAMPLES      (MAX_SAMPLES),
    .THRESH_FRAC_BITS (THRESH_FRAC_BITS)
  ) u_step (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .sample_value    (sample_in.sample_value),
    .last_sample     (sample_in.last_sample),
    .noise_threshold (noise_threshold),
    .pedestal        (pedestal),
    .push            (push)
  );

  // Results wait here so the input side keeps moving while the sink stalls.
  wps_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .pop_ready    (peak_out.ready),
    .pop_valid    (peak_out.valid),
    .head         (head),
    .room_for_two (room_for_two)
  );

  assign peak_out.peak_index       = head.peak_index;
  assign peak_out.peak_amplitude   = head.peak_amplitude;
  assign peak_out.last_of_waveform = head.last_of_waveform;

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Testbench for the waveform peak segmenter: directed and random waveforms, scoreboard check.
`default_nettype none
module tb_top
  import wps_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Block configuration under test; the predictor below uses the same values.
  localparam int SAMPLE_BITS      = 12;
  localparam int MAX_SAMPLES      = 256;
  localparam int THRESH_FRAC_BITS = 4;

  // Cycles to hold after the last expected item before a register write or the end.
  localparam int SETTLE_CYCLES  = 4;
  // Cycles with no item moving on either channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1200;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
  peak_if                                peak_ch ();

  waveform_peak_segmenter_core #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .MAX_SAMPLES      (MAX_SAMPLES),
    .THRESH_FRAC_BITS (THRESH_FRAC_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_in (sample_ch),
    .peak_out  (peak_ch)
  );

  // ---------------------------------------------------------------------------
  // Clock: 10 ns period.
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Peak predictor: its own copy of the registers and of the segment state.
  // ---------------------------------------------------------------------------
  logic [THRESH_W-1:0]      thresh_reg;
  logic [PEDESTAL_W-1:0]    pedestal_reg;
  logic [INDEX_W-1:0]       next_index;
  logic [SAMPLE_BITS-1:0]   prev_value;
  logic [SAMPLE_BITS-1:0]   seg_max;
  logic [INDEX_W-1:0]       seg_max_idx;
  logic                     seg_falling;
  logic                     seg_active;

  // Peaks predicted but not yet seen on the output, oldest first.
  peak_t peaks_pending[$];

  int unsigned mismatch_count;

  // Idling profile of each side: 0 means no gaps at all.
  int src_gap_max;
  int sink_gap_max;
  int sink_stall;

  // A step counts when it is strictly larger than the threshold, which has
  // THRESH_FRAC_BITS fraction bits: compare the scaled difference exactly.
  function automatic bit step_exceeds(input int diff);
    return (diff * (1 << THRESH_FRAC_BITS)) > int'(thresh_reg);
  endfunction

  function automatic void open_segment(input logic [SAMPLE_BITS-1:0] v,
                                       input logic [INDEX_W-1:0] idx);
    seg_max     = v;
    seg_max_idx = idx;
    prev_value  = v;
    seg_falling = 1'b0;
    seg_active  = 1'b1;
  endfunction

  function automatic void queue_peak(input logic is_last);
    peak_t                  p;
    logic [AMPLITUDE_W-1:0] amp;
    // Amplitude wraps to the output width, so a pedestal above the maximum
    // shows up as a negative two's complement value.
    amp = AMPLITUDE_W'(seg_max) - AMPLITUDE_W'(pedestal_reg);
    p.peak_index       = seg_max_idx;
    p.peak_amplitude   = amp;
    p.last_of_waveform = is_last;
    peaks_pending = {peaks_pending, p};
  endfunction

  function automatic void predict_peaks(input logic [SAMPLE_BITS-1:0] v, input logic is_last);
    logic [INDEX_W-1:0] idx;
    int                 fall;
    idx = next_index;
    if (!seg_active) begin
      open_segment(v, idx);
    end else begin
      fall = int'(prev_value) - int'(v);
      if (step_exceeds(fall)) seg_falling = 1'b1;
      if (seg_falling && step_exceeds(-fall)) begin
        // Rise after a fall: close the segment, the rising sample opens the next.
        queue_peak(1'b0);
        open_segment(v, idx);
      end else begin
        // Ties keep the first position of the maximum.
        if (v > seg_max) begin
          seg_max     = v;
          seg_max_idx = idx;
        end
        prev_value = v;
      end
    end
    if (is_last) begin
      queue_peak(1'b1);
      seg_active  = 1'b0;
      seg_falling = 1'b0;
      next_index  = '0;
    end else if (int'(idx) < MAX_SAMPLES - 1) begin
      // Index saturates at the top; later samples share it.
      next_index = idx + 1'b1;
    end
  endfunction

  function automatic int draw_gap(input int max_gap);
    if (max_gap == 0) return 0;
    // Favor back-to-back items half of the time.
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, max_gap);
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: ready driver and result check.
  // ---------------------------------------------------------------------------
  // Drive ready at the falling edge; the stall count is drawn after each
  // accepted item by the checker.
  always @(negedge clk) begin
    if (sink_stall > 0) begin
      peak_ch.ready <= 1'b0;
      sink_stall    <= sink_stall - 1;
    end else begin
      peak_ch.ready <= 1'b1;
    end
  end

  // Compare every accepted peak item, field by field, with the oldest prediction.
  always @(posedge clk) begin
    peak_t got;
    peak_t want;
    if (!rst && peak_ch.valid && peak_ch.ready) begin
      got.peak_index       = peak_ch.peak_index;
      got.peak_amplitude   = peak_ch.peak_amplitude;
      got.last_of_waveform = peak_ch.last_of_waveform;
      if (peaks_pending.size() == 0) begin
        $display("%0t: unexpected peak item: index %0d amplitude %0d last %0b", $time,
                 got.peak_index, got.peak_amplitude, got.last_of_waveform);
        mismatch_count++;
      end else begin
        want = peaks_pending.pop_front();
        if (got.peak_index !== want.peak_index) begin
          $display("%0t: peak_index expected %0d actual %0d", $time,
                   want.peak_index, got.peak_index);
          mismatch_count++;
        end
        if (got.peak_amplitude !== want.peak_amplitude) begin
          $display("%0t: peak_amplitude expected %0d actual %0d", $time,
                   want.peak_amplitude, got.peak_amplitude);
          mismatch_count++;
        end
        if (got.last_of_waveform !== want.last_of_waveform) begin
          $display("%0t: last_of_waveform expected %0b actual %0b", $time,
                   want.last_of_waveform, got.last_of_waveform);
          mismatch_count++;
        end
      end
      sink_stall <= draw_gap(sink_gap_max);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves for too long.
  // ---------------------------------------------------------------------------
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (peak_ch.valid && peak_ch.ready)
        || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d peak items outstanding", $time,
               peaks_pending.size());
      $display("** waveform_peak_segmenter_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks.
  // ---------------------------------------------------------------------------
  // Send one sample item. Each call starts just after a rising edge; valid is
  // left high on return so that a following item can go back to back.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] v, input logic is_last);
    int gap;
    gap = draw_gap(src_gap_max);
    repeat (gap) begin
      @(negedge clk);
      sample_ch.valid <= 1'b0;
    end
    @(negedge clk);
    sample_ch.valid        <= 1'b1;
    sample_ch.sample_value <= v;
    sample_ch.last_sample  <= is_last;
    do @(posedge clk); while (!sample_ch.ready);
    predict_peaks(v, is_last);
  endtask

  // Drop valid, then hold until every predicted peak has come out and the
  // block has had time to settle.
  task automatic drain_peaks();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (peaks_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_NOISE_THRESHOLD: thresh_reg   = data[THRESH_W-1:0];
      REG_PEDESTAL:        pedestal_reg = data[PEDESTAL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Change both registers while the block is idle.
  task automatic apply_setting(input logic [THRESH_W-1:0] thr,
                               input logic [PEDESTAL_W-1:0] ped);
    drain_peaks();
    write_reg(REG_NOISE_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_PEDESTAL, CFG_DATA_W'(ped));
  endtask

  // Send one waveform of random content; the final sample carries the last mark.
  // Styles: pulse-like random walk (most), uniform noise, and flat lines.
  task automatic send_waveform(input int len);
    int                     style;
    int                     level;
    int                     step_max;
    int                     k;
    logic [SAMPLE_BITS-1:0] v;
    style    = $urandom_range(0, 9);
    level    = $urandom_range(0, (1 << SAMPLE_BITS) - 1);
    step_max = ($urandom_range(0, 1) == 0) ? 16 : 1024;
    for (k = 0; k < len; k++) begin
      if (style <= 6) begin
        level = level + int'($urandom_range(0, 2 * step_max)) - step_max;
        if (level < 0) level = 0;
        if (level > (1 << SAMPLE_BITS) - 1) level = (1 << SAMPLE_BITS) - 1;
        v = level[SAMPLE_BITS-1:0];
      end else if (style <= 8) begin
        v = SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
      end else begin
        v = level[SAMPLE_BITS-1:0];
      end
      send_sample(v, k == len - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  // Directed: extremes, ties, the threshold boundary, a rise on the last
  // sample, and both register extremes.
  task automatic test_directed();
    src_gap_max  = 0;
    sink_gap_max = 0;
    // Single-sample waveforms at both ends of the sample range.
    send_sample(12'd4095, 1'b1);
    send_sample(12'd0, 1'b1);
    // Default threshold 32 with 4 fraction bits: a step of 2 stays under,
    // a step of 3 goes over.
    send_sample(12'd1000, 1'b0);
    send_sample(12'd1200, 1'b0);
    send_sample(12'd1200, 1'b0);   // tie keeps the first position
    send_sample(12'd1198, 1'b0);   // fall of 2: not falling yet
    send_sample(12'd1195, 1'b0);   // fall of 3: falling
    send_sample(12'd1197, 1'b0);   // rise of 2: segment stays open
    send_sample(12'd1200, 1'b0);   // rise of 3: close and reopen
    send_sample(12'd1100, 1'b0);
    send_sample(12'd4095, 1'b1);   // rise on the last sample: two peaks
    // Zero threshold and top pedestal: any step counts, amplitudes go zero or negative.
    apply_setting(16'd0, 12'd4095);
    send_sample(12'd0, 1'b0);
    send_sample(12'd1, 1'b0);
    send_sample(12'd0, 1'b0);
    send_sample(12'd1, 1'b0);
    send_sample(12'd4095, 1'b1);
    // Top threshold: no step can exceed it, so one segment per waveform.
    apply_setting(16'hFFFF, 12'd0);
    send_sample(12'd0, 1'b0);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd0, 1'b0);
    send_sample(12'd4095, 1'b1);
  endtask

  // Waveforms up to and beyond the index range: the index saturates at the top.
  task automatic test_long_waveform();
    apply_setting(16'd48, 12'd200);
    src_gap_max  = 0;
    sink_gap_max = 4;
    send_waveform(MAX_SAMPLES + 40);
    src_gap_max  = 3;
    sink_gap_max = 0;
    send_waveform(MAX_SAMPLES - 1);
    send_waveform(MAX_SAMPLES);
  endtask

  // Random waveforms over several register settings and idling profiles.
  task automatic test_random_waveforms();
    logic [THRESH_W-1:0]   thr_list[8];
    logic [PEDESTAL_W-1:0] ped_list[8];
    int                    phase;
    int                    sent;
    int                    len;
    thr_list = '{16'd32, 16'd0, 16'hFFFF, 16'd1, 16'd16, 16'd0, 16'd0, 16'd0};
    ped_list = '{12'd0, 12'd0, 12'd4095, 12'd4095, 12'd100, 12'd0, 12'd0, 12'd0};
    for (phase = 0; phase < 8; phase++) begin
      // Last three phases take random register values.
      if (phase >= 5) begin
        thr_list[phase] = THRESH_W'($urandom_range(0, 2047));
        ped_list[phase] = PEDESTAL_W'($urandom_range(0, 4095));
      end
      apply_setting(thr_list[phase], ped_list[phase]);
      case (phase % 4)
        0: begin src_gap_max = 0;  sink_gap_max = 0;  end
        1: begin src_gap_max = 16; sink_gap_max = 16; end
        2: begin src_gap_max = 0;  sink_gap_max = 16; end
        default: begin src_gap_max = 16; sink_gap_max = 0; end
      endcase
      sent = 0;
      while (sent < RANDOM_ITEMS / 8) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 24);
        send_waveform(len);
        sent += len;
        // Now and then hold the sender until the output has caught up.
        if ($urandom_range(0, 15) == 0) drain_peaks();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = REG_NOISE_THRESHOLD;
    cfg_data               = '0;
    sample_ch.valid        = 1'b0;
    sample_ch.sample_value = '0;
    sample_ch.last_sample  = 1'b0;
    peak_ch.ready          = 1'b0;
    sink_stall             = 0;
    src_gap_max            = 0;
    sink_gap_max           = 0;
    mismatch_count         = 0;
    idle_cycles            = 0;
    // Predictor starts from the reset state of the block.
    thresh_reg   = THRESH_RESET;
    pedestal_reg = PEDESTAL_RESET;
    next_index   = '0;
    prev_value   = '0;
    seg_max      = '0;
    seg_max_idx  = '0;
    seg_falling  = 1'b0;
    seg_active   = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_long_waveform();
    test_random_waveforms();

    drain_peaks();
    if (peaks_pending.size() != 0) begin
      $display("%0t: %0d predicted peak items never arrived", $time, peaks_pending.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("** waveform_peak_segmenter_core: PASSED **");
    end else begin
      $display("** waveform_peak_segmenter_core: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
